// ===== hdl/slid_pkg.sv =====
// Shared types and constants of the sequence list block.
`default_nettype none

package slid_pkg;

  localparam int CapacityDef = 64;
  localparam int DataW       = 32;
  localparam int CountW      = 7;
  localparam int PosW        = 7;
  localparam int ActW        = 2;
  localparam int StatW       = 3;
  localparam int InTdataW    = 104;
  localparam int InTuserW    = 2;
  localparam int OutTdataW   = 32;
  localparam int OutTuserW   = 3;

  typedef enum logic [ActW-1:0] {
    ACT_APPEND  = 2'd0,
    ACT_PREPEND = 2'd1,
    ACT_REMOVE  = 2'd2,
    ACT_READ    = 2'd3
  } action_e;

  typedef enum logic [StatW-1:0] {
    STAT_ELEM   = 3'd0,
    STAT_DONE   = 3'd1,
    STAT_FULL   = 3'd2,
    STAT_BADPOS = 3'd3,
    STAT_EMPTY  = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_DECODE,
    S_APPEND,
    S_SHIFT,
    S_DRAIN,
    S_FILL,
    S_RD_READ,
    S_RD_LOAD,
    S_RESP
  } state_e;

  typedef enum logic [2:0] {
    IDX_HOLD,
    IDX_LAST,
    IDX_POS,
    IDX_ZERO,
    IDX_INC,
    IDX_DEC
  } idx_op_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    capture;
    logic    init_wr;
    logic    ins_wr;
    logic    ins_front;
    logic    k_clr;
    logic    k_inc;
    idx_op_e idx_op;
    logic    ram_rd;
    logic    mv_rd;
    logic    mv_front;
    logic    cnt_add3;
    logic    cnt_dec;
    logic    out_load;
    logic    out_ram;
    logic    out_last;
    status_e out_status;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    action_e action;
    logic    cnt_zero;
    logic    full;
    logic    pos_bad;
    logic    pos_is_last;
    logic    idx_zero;
    logic    idx_last;
    logic    k_last;
    logic    out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

// ===== hdl/sequence_list_insert_delete.sv =====
// Top level of the sequence list block: stream ports, controller and datapath.
`default_nettype none

// Keeps an ordered list of signed 32-bit values, holding the single value 1
// after reset, and executes one command per input request: append three
// values, prepend three values, remove at a 1-based position, or read out the
// whole list. Every command answers with one status result, except a readout
// of a non-empty list, which answers with one result per element and marks
// the final one with tlast. One command is processed at a time; a request is
// taken only while the controller is idle. The list lives in a single RAM with
// one read and one write port, so a prepend moves one entry per cycle, three
// places up, and a removal moves each entry after the removed position one
// place down; a readout reads and loads one element at a time and waits while
// the output is stalled. After reset, the init state writes the initial entry
// before the first request is taken.
module sequence_list_insert_delete #(
  parameter int CAPACITY = slid_pkg::CapacityDef
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  // value_first [31:0], value_second [63:32], value_third [95:64],
  // position [102:96], zero fill [103].
  input  wire logic [slid_pkg::InTdataW-1:0]    s_axis_tdata,
  // action [1:0].
  input  wire logic [slid_pkg::InTuserW-1:0]    s_axis_tuser,
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  // element [31:0].
  output logic [slid_pkg::OutTdataW-1:0]        m_axis_tdata,
  // status [2:0].
  output logic [slid_pkg::OutTuserW-1:0]        m_axis_tuser,
  output logic                                  m_axis_tlast
);

  import slid_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;
  status_e   status;
  logic signed [DataW-1:0] element;

  slid_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  slid_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .action_i       (action_e'(s_axis_tuser)),
    .value_first_i  (s_axis_tdata[31:0]),
    .value_second_i (s_axis_tdata[63:32]),
    .value_third_i  (s_axis_tdata[95:64]),
    .position_i     (s_axis_tdata[102:96]),
    .out_ready_i    (m_axis_tready),
    .out_valid_o    (m_axis_tvalid),
    .element_o      (element),
    .status_o       (status),
    .last_o         (m_axis_tlast)
  );

  assign m_axis_tdata = element;
  assign m_axis_tuser = status;

endmodule

`default_nettype wire

// ===== hdl/slid_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module slid_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     wr_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  wire logic [WIDTH-1:0]         wr_data_i,
  input  wire logic                     rd_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic      [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

// ===== hdl/slid_ctrl.sv =====
// Controller state machine that sequences each list command.
`default_nettype none

module slid_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire slid_pkg::dp_stat_t stat_i,
  output slid_pkg::ctrl_cmd_t    cmd_o
);

  import slid_pkg::*;

  state_e  state_q, state_d;
  status_e resp_q, resp_d;
  logic    is_front;

  assign is_front = (stat_i.action == ACT_PREPEND);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
      resp_q  <= STAT_DONE;
    end else begin
      state_q <= state_d;
      resp_q  <= resp_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    resp_d  = resp_q;
    unique case (state_q)
      S_INIT: state_d = S_IDLE;
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (stat_i.action)
          ACT_APPEND: begin
            if (stat_i.full) begin
              resp_d  = STAT_FULL;
              state_d = S_RESP;
            end else begin
              state_d = S_APPEND;
            end
          end
          ACT_PREPEND: begin
            if (stat_i.full) begin
              resp_d  = STAT_FULL;
              state_d = S_RESP;
            end else if (stat_i.cnt_zero) begin
              state_d = S_FILL;
            end else begin
              state_d = S_SHIFT;
            end
          end
          ACT_REMOVE: begin
            if (stat_i.pos_bad) begin
              resp_d  = STAT_BADPOS;
              state_d = S_RESP;
            end else if (stat_i.pos_is_last) begin
              resp_d  = STAT_DONE;
              state_d = S_RESP;
            end else begin
              state_d = S_SHIFT;
            end
          end
          ACT_READ: begin
            if (stat_i.cnt_zero) begin
              resp_d  = STAT_EMPTY;
              state_d = S_RESP;
            end else begin
              state_d = S_RD_READ;
            end
          end
          default: state_d = S_IDLE;
        endcase
      end
      S_APPEND, S_FILL: begin
        if (stat_i.k_last) begin
          resp_d  = STAT_DONE;
          state_d = S_RESP;
        end
      end
      S_SHIFT: begin
        if (is_front ? stat_i.idx_zero : stat_i.idx_last) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (is_front) begin
          state_d = S_FILL;
        end else begin
          resp_d  = STAT_DONE;
          state_d = S_RESP;
        end
      end
      S_RD_READ: state_d = S_RD_LOAD;
      S_RD_LOAD: begin
        if (stat_i.out_free) begin
          state_d = stat_i.idx_last ? S_IDLE : S_RD_READ;
        end
      end
      S_RESP: begin
        if (stat_i.out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd_o            = '0;
    cmd_o.idx_op     = IDX_HOLD;
    cmd_o.out_status = STAT_ELEM;
    in_ready_o       = 1'b0;
    unique case (state_q)
      S_INIT: cmd_o.init_wr = 1'b1;
      S_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      S_DECODE: begin
        cmd_o.k_clr = 1'b1;
        unique case (stat_i.action)
          ACT_PREPEND: cmd_o.idx_op = IDX_LAST;
          ACT_REMOVE: begin
            cmd_o.idx_op  = IDX_POS;
            cmd_o.cnt_dec = !stat_i.pos_bad && stat_i.pos_is_last;
          end
          ACT_READ: cmd_o.idx_op = IDX_ZERO;
          default:  cmd_o.idx_op = IDX_HOLD;
        endcase
      end
      S_APPEND, S_FILL: begin
        cmd_o.ins_wr    = 1'b1;
        cmd_o.ins_front = (state_q == S_FILL);
        cmd_o.k_inc     = 1'b1;
        cmd_o.cnt_add3  = stat_i.k_last;
      end
      S_SHIFT: begin
        cmd_o.ram_rd   = 1'b1;
        cmd_o.mv_rd    = 1'b1;
        cmd_o.mv_front = is_front;
        cmd_o.idx_op   = is_front ? IDX_DEC : IDX_INC;
      end
      S_DRAIN: cmd_o.cnt_dec = !is_front;
      S_RD_READ: cmd_o.ram_rd = 1'b1;
      S_RD_LOAD: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_ram  = 1'b1;
          cmd_o.out_last = stat_i.idx_last;
          cmd_o.idx_op   = IDX_INC;
        end
      end
      S_RESP: begin
        if (stat_i.out_free) begin
          cmd_o.out_load   = 1'b1;
          cmd_o.out_last   = 1'b1;
          cmd_o.out_status = resp_q;
        end
      end
      default: cmd_o.idx_op = IDX_HOLD;
    endcase
  end

endmodule

`default_nettype wire

// ===== hdl/slid_dp.sv =====
// Datapath: command registers, list store, counters and output register.
`default_nettype none

module slid_dp #(
  parameter int CAPACITY = slid_pkg::CapacityDef
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire slid_pkg::ctrl_cmd_t            cmd_i,
  output slid_pkg::dp_stat_t                  stat_o,
  input  wire slid_pkg::action_e              action_i,
  input  wire logic signed [slid_pkg::DataW-1:0] value_first_i,
  input  wire logic signed [slid_pkg::DataW-1:0] value_second_i,
  input  wire logic signed [slid_pkg::DataW-1:0] value_third_i,
  input  wire logic [slid_pkg::PosW-1:0]      position_i,
  input  wire logic                           out_ready_i,
  output logic                                out_valid_o,
  output logic signed [slid_pkg::DataW-1:0]   element_o,
  output slid_pkg::status_e                   status_o,
  output logic                                last_o
);

  import slid_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam logic [CountW-1:0] CapC = CountW'(CAPACITY);

  action_e            act_q;
  logic [DataW-1:0]   val_a_q, val_b_q, val_c_q;
  logic [PosW-1:0]    pos_q;
  logic [CountW-1:0]  count_q, count_d;
  logic [CountW-1:0]  cnt_m1;
  logic [CountW-1:0]  cnt_p3;
  logic [AW-1:0]      idx_q, idx_d;
  logic [1:0]         k_q, k_d;
  logic               pend_q;
  logic [AW-1:0]      pend_addr_q;
  logic               out_valid_q, out_valid_d;
  logic [DataW-1:0]   out_elem_q;
  status_e            out_stat_q;
  logic               out_last_q;

  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic [DataW-1:0]   wr_data;
  logic [DataW-1:0]   ins_data;
  logic [DataW-1:0]   rd_data;

  assign cnt_m1 = count_q - CountW'(1);
  assign cnt_p3 = count_q + CountW'(3);

  // Command capture.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      val_a_q <= value_first_i;
      val_b_q <= value_second_i;
      val_c_q <= value_third_i;
      pos_q   <= position_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q       <= ACT_APPEND;
      count_q     <= CountW'(1);
      idx_q       <= '0;
      k_q         <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.capture) begin
        act_q <= action_i;
      end
      count_q     <= count_d;
      idx_q       <= idx_d;
      k_q         <= k_d;
      pend_q      <= cmd_i.mv_rd;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    count_d = count_q;
    if (cmd_i.cnt_add3) begin
      count_d = cnt_p3;
    end else if (cmd_i.cnt_dec) begin
      count_d = cnt_m1;
    end
  end

  always_comb begin
    unique case (cmd_i.idx_op)
      IDX_LAST: idx_d = cnt_m1[AW-1:0];
      IDX_POS:  idx_d = pos_q[AW-1:0];
      IDX_ZERO: idx_d = '0;
      IDX_INC:  idx_d = idx_q + AW'(1);
      IDX_DEC:  idx_d = idx_q - AW'(1);
      default:  idx_d = idx_q;
    endcase
  end

  always_comb begin
    k_d = k_q;
    if (cmd_i.k_clr) begin
      k_d = '0;
    end else if (cmd_i.k_inc) begin
      k_d = k_q + 2'd1;
    end
  end

  // An entry read during a shift is written back in the following cycle, three
  // places up for a prepend or one place down for a removal.
  always_ff @(posedge clk_i) begin
    if (cmd_i.mv_rd) begin
      pend_addr_q <= cmd_i.mv_front ? idx_q + AW'(3) : idx_q - AW'(1);
    end
  end

  always_comb begin
    case (k_q)
      2'd0:    ins_data = val_a_q;
      2'd1:    ins_data = val_b_q;
      default: ins_data = val_c_q;
    endcase
  end

  always_comb begin
    wr_en   = pend_q | cmd_i.init_wr | cmd_i.ins_wr;
    wr_addr = '0;
    wr_data = DataW'(1);
    if (pend_q) begin
      wr_addr = pend_addr_q;
      wr_data = rd_data;
    end else if (cmd_i.ins_wr) begin
      wr_addr = cmd_i.ins_front ? AW'(k_q) : count_q[AW-1:0] + AW'(k_q);
      wr_data = ins_data;
    end
  end

  slid_ram #(
    .WIDTH (DataW),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (cmd_i.ram_rd),
    .rd_addr_i (idx_q),
    .rd_data_o (rd_data)
  );

  // Output register.
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_elem_q <= cmd_i.out_ram ? rd_data : '0;
      out_stat_q <= cmd_i.out_status;
      out_last_q <= cmd_i.out_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign element_o   = out_elem_q;
  assign status_o    = out_stat_q;
  assign last_o      = out_last_q;

  always_comb begin
    stat_o.action      = act_q;
    stat_o.cnt_zero    = (count_q == '0);
    stat_o.full        = (cnt_p3 > CapC);
    stat_o.pos_bad     = (pos_q == '0) || (pos_q > count_q);
    stat_o.pos_is_last = (pos_q == count_q);
    stat_o.idx_zero    = (idx_q == '0);
    stat_o.idx_last    = (idx_q == cnt_m1[AW-1:0]);
    stat_o.k_last      = (k_q == 2'd2);
    stat_o.out_free    = !out_valid_q || out_ready_i;
  end

endmodule

`default_nettype wire
